// ===== rtl/core/tbs_pkg.sv =====
package tbs_pkg;

  localparam int MAX_READINGS = 128;
  localparam int SAMPLE_W     = 16;
  localparam int VAL_W        = SAMPLE_W - 1;
  localparam int CNT_W        = $clog2(MAX_READINGS + 1);
  localparam int SUM_W        = VAL_W + $clog2(MAX_READINGS);
  localparam int SUM_HI_W     = SUM_W - VAL_W;
  localparam int BIT_CNT_W    = $clog2(VAL_W);
  localparam int DIV_CNT_W    = $clog2(SUM_W);
  localparam int REM_W        = CNT_W + 1;
  localparam int BANDS        = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN = 2'd2;

  localparam logic [VAL_W-1:0] WARN_RESET     = 15'd480;
  localparam logic [VAL_W-1:0] CRITICAL_RESET = 15'd720;
  localparam logic [VAL_W-1:0] SHUTDOWN_RESET = 15'd960;

  typedef enum logic [1:0] {
    BAND_NORMAL   = 2'd0,
    BAND_WARNING  = 2'd1,
    BAND_CRITICAL = 2'd2,
    BAND_SHUTDOWN = 2'd3
  } band_e;

endpackage

// ===== rtl/core/tbs_cfg_if.sv =====
interface tbs_cfg_if;
  import tbs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tbs_in_if.sv =====
interface tbs_in_if;
  import tbs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] reading;
  logic                       last_reading;

  modport source (output valid, output reading, output last_reading, input ready);
  modport sink (input valid, input reading, input last_reading, output ready);
endinterface

// ===== rtl/core/tbs_out_if.sv =====
interface tbs_out_if;
  import tbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] skipped_count;
  logic [VAL_W-1:0] minimum;
  logic [VAL_W-1:0] maximum;
  logic [VAL_W-1:0] average;
  logic [CNT_W-1:0] first_critical_index;
  logic [VAL_W-1:0] first_critical_value;
  logic [CNT_W-1:0] normal_count;
  logic [CNT_W-1:0] warning_count;
  logic [CNT_W-1:0] critical_count;
  logic [CNT_W-1:0] shutdown_count;
  logic             overlong;

  modport source (
    output valid, input ready,
    output valid_count, output skipped_count, output minimum, output maximum,
    output average, output first_critical_index, output first_critical_value,
    output normal_count, output warning_count, output critical_count,
    output shutdown_count, output overlong
  );
  modport sink (
    input valid, output ready,
    input valid_count, input skipped_count, input minimum, input maximum,
    input average, input first_critical_index, input first_critical_value,
    input normal_count, input warning_count, input critical_count,
    input shutdown_count, input overlong
  );
endinterface

// ===== rtl/core/temperature_batch_statistics_unit.sv =====
// Batch statistics over signed Q11.4 temperature readings, one reading per input transfer,
// with last_reading closing the batch and producing one summary transfer. Readings are
// processed bit-serially, least significant bit first, through shift registers: a valid
// (non-negative, in-capacity) reading goes through accept, 15-bit serial pass, commit;
// a negative reading or one beyond 128 readings is done at accept. Closing a batch adds
// the bit-serial restoring division forming the average (22 quotient bits) and any wait for
// the summary output register to drain. The user must write thresholds through the
// configuration port by index (0 warn, 1 critical, 2 shutdown) while idle; not enforced.
module temperature_batch_statistics_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbs_cfg_if.sink   cfg_i,
  tbs_in_if.sink    in_i,
  tbs_out_if.source out_o
);
  import tbs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PASS   = 6'b000010,
    ST_COMMIT = 6'b000100,
    ST_START  = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [VAL_W-1:0]     warn_q, crit_q, shut_q;
  logic [CNT_W-1:0]     pos_q, valid_seen_q, error_seen_q;
  logic [VAL_W-1:0]     sum_lo_q;
  logic [SUM_HI_W-1:0]  sum_hi_q;
  logic [VAL_W-1:0]     lowest_q, highest_q;
  logic [CNT_W-1:0]     crit_pos_q;
  logic [VAL_W-1:0]     crit_val_q;
  logic [CNT_W-1:0]     band_q [BANDS];
  logic                 overflow_q;
  logic                 last_q;
  logic [VAL_W-1:0]     samp_q, warn_sh_q, crit_sh_q, shut_sh_q;
  logic                 lt_low_q, gt_high_q, lt_warn_q, lt_crit_q, lt_shut_q, carry_q;
  logic [BIT_CNT_W-1:0] bit_cnt_q;

  logic                 out_valid_q;
  logic [CNT_W-1:0]     o_valid_cnt_q, o_skip_cnt_q, o_crit_idx_q;
  logic [VAL_W-1:0]     o_min_q, o_max_q, o_avg_q, o_crit_val_q;
  logic [CNT_W-1:0]     o_band_q [BANDS];
  logic                 o_overlong_q;

  logic                 in_accept, in_sign, full, emit_ok, pass_end;
  logic [VAL_W-1:0]     in_val;
  logic                 s_bit;
  logic [1:0]           bit_sum;
  band_e                band_sel;
  logic                 div_start, div_done;
  logic [VAL_W-1:0]     quotient;

  assign in_i.ready = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign in_accept  = in_i.valid && in_i.ready;
  assign in_sign    = in_i.reading[SAMPLE_W-1];
  assign in_val     = in_i.reading[VAL_W-1:0];
  assign full       = pos_q >= CNT_W'(MAX_READINGS);
  assign emit_ok    = !out_valid_q || out_o.ready;
  assign pass_end   = bit_cnt_q == BIT_CNT_W'(VAL_W - 1);
  assign s_bit      = samp_q[0];
  assign bit_sum    = {1'b0, sum_lo_q[0]} + {1'b0, s_bit} + {1'b0, carry_q};
  assign div_start  = state_q == ST_START;

  always_comb begin
    if (lt_warn_q) begin
      band_sel = BAND_NORMAL;
    end else if (lt_crit_q) begin
      band_sel = BAND_WARNING;
    end else if (lt_shut_q) begin
      band_sel = BAND_CRITICAL;
    end else begin
      band_sel = BAND_SHUTDOWN;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!full && !in_sign) begin
            state_d = ST_PASS;
          end else if (in_i.last_reading) begin
            state_d = ST_START;
          end
        end
      end
      ST_PASS: begin
        if (pass_end) state_d = ST_COMMIT;
      end
      ST_COMMIT: state_d = last_q ? ST_START : ST_IDLE;
      ST_START:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  tbs_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_hi_q, sum_lo_q}),
    .divisor_i  (valid_seen_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q <= WARN_RESET;
      crit_q <= CRITICAL_RESET;
      shut_q <= SHUTDOWN_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_WARN:     warn_q <= cfg_i.data;
        CFG_CRITICAL: crit_q <= cfg_i.data;
        CFG_SHUTDOWN: shut_q <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      valid_seen_q <= '0;
      error_seen_q <= '0;
      sum_lo_q     <= '0;
      sum_hi_q     <= '0;
      lowest_q     <= '0;
      highest_q    <= '0;
      crit_pos_q   <= CNT_W'(MAX_READINGS);
      crit_val_q   <= '0;
      for (int i = 0; i < BANDS; i++) band_q[i] <= '0;
      overflow_q   <= 1'b0;
      last_q       <= 1'b0;
      bit_cnt_q    <= '0;
      carry_q      <= 1'b0;
      lt_low_q     <= 1'b0;
      gt_high_q    <= 1'b0;
      lt_warn_q    <= 1'b0;
      lt_crit_q    <= 1'b0;
      lt_shut_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            last_q <= in_i.last_reading;
            if (full) begin
              overflow_q <= 1'b1;
            end else if (in_sign) begin
              error_seen_q <= error_seen_q + CNT_W'(1);
              pos_q        <= pos_q + CNT_W'(1);
            end else begin
              bit_cnt_q <= '0;
              carry_q   <= 1'b0;
              lt_low_q  <= 1'b0;
              gt_high_q <= 1'b0;
              lt_warn_q <= 1'b0;
              lt_crit_q <= 1'b0;
              lt_shut_q <= 1'b0;
            end
          end
        end
        ST_PASS: begin
          bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
          carry_q   <= bit_sum[1];
          sum_lo_q  <= {bit_sum[0], sum_lo_q[VAL_W-1:1]};
          lowest_q  <= {lowest_q[0], lowest_q[VAL_W-1:1]};
          highest_q <= {highest_q[0], highest_q[VAL_W-1:1]};
          if (s_bit != lowest_q[0])   lt_low_q  <= lowest_q[0];
          if (s_bit != highest_q[0])  gt_high_q <= s_bit;
          if (s_bit != warn_sh_q[0])  lt_warn_q <= warn_sh_q[0];
          if (s_bit != crit_sh_q[0])  lt_crit_q <= crit_sh_q[0];
          if (s_bit != shut_sh_q[0])  lt_shut_q <= shut_sh_q[0];
        end
        ST_COMMIT: begin
          if (valid_seen_q == '0 || lt_low_q)  lowest_q  <= samp_q;
          if (valid_seen_q == '0 || gt_high_q) highest_q <= samp_q;
          valid_seen_q <= valid_seen_q + CNT_W'(1);
          pos_q        <= pos_q + CNT_W'(1);
          sum_hi_q     <= sum_hi_q + SUM_HI_W'(carry_q);
          if (crit_pos_q == CNT_W'(MAX_READINGS) && !lt_crit_q) begin
            crit_pos_q <= pos_q;
            crit_val_q <= samp_q;
          end
          band_q[band_sel] <= band_q[band_sel] + CNT_W'(1);
        end
        ST_EMIT: begin
          if (emit_ok) begin
            pos_q        <= '0;
            valid_seen_q <= '0;
            error_seen_q <= '0;
            sum_lo_q     <= '0;
            sum_hi_q     <= '0;
            lowest_q     <= '0;
            highest_q    <= '0;
            crit_pos_q   <= CNT_W'(MAX_READINGS);
            crit_val_q   <= '0;
            for (int i = 0; i < BANDS; i++) band_q[i] <= '0;
            overflow_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept) begin
      samp_q    <= in_val;
      warn_sh_q <= warn_q;
      crit_sh_q <= crit_q;
      shut_sh_q <= shut_q;
    end else if (state_q == ST_PASS) begin
      samp_q    <= {samp_q[0], samp_q[VAL_W-1:1]};
      warn_sh_q <= {1'b0, warn_sh_q[VAL_W-1:1]};
      crit_sh_q <= {1'b0, crit_sh_q[VAL_W-1:1]};
      shut_sh_q <= {1'b0, shut_sh_q[VAL_W-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && emit_ok) begin
      o_valid_cnt_q <= valid_seen_q;
      o_skip_cnt_q  <= error_seen_q;
      o_min_q       <= lowest_q;
      o_max_q       <= highest_q;
      o_avg_q       <= (valid_seen_q == '0) ? '0 : quotient;
      o_crit_idx_q  <= crit_pos_q;
      o_crit_val_q  <= crit_val_q;
      for (int i = 0; i < BANDS; i++) o_band_q[i] <= band_q[i];
      o_overlong_q  <= overflow_q;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.valid_count          = o_valid_cnt_q;
  assign out_o.skipped_count        = o_skip_cnt_q;
  assign out_o.minimum              = o_min_q;
  assign out_o.maximum              = o_max_q;
  assign out_o.average              = o_avg_q;
  assign out_o.first_critical_index = o_crit_idx_q;
  assign out_o.first_critical_value = o_crit_val_q;
  assign out_o.normal_count         = o_band_q[BAND_NORMAL];
  assign out_o.warning_count        = o_band_q[BAND_WARNING];
  assign out_o.critical_count       = o_band_q[BAND_CRITICAL];
  assign out_o.shutdown_count       = o_band_q[BAND_SHUTDOWN];
  assign out_o.overlong             = o_overlong_q;

  a_pos_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, valid_seen_q} + {1'b0, error_seen_q}) == {1'b0, pos_q})
    else $error("position differs from valid plus skipped");
  a_band_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({2'b0, band_q[0]} + {2'b0, band_q[1]} + {2'b0, band_q[2]} + {2'b0, band_q[3]})
      == {2'b0, valid_seen_q})
    else $error("band counts do not add up to valid count");
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("summary loaded outside emit");
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && valid_seen_q != '0) |-> lowest_q <= highest_q)
    else $error("minimum above maximum");
endmodule

// ===== rtl/core/tbs_serial_div.sv =====
module tbs_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tbs_pkg::SUM_W-1:0]    dividend_i,
  input  logic [tbs_pkg::CNT_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [tbs_pkg::VAL_W-1:0]    quotient_o
);
  import tbs_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     div_q;
  logic [CNT_W-1:0]     rem_q;
  logic [REM_W-1:0]     trial;
  logic [REM_W-1:0]     diff;
  logic                 fits;

  assign trial = {rem_q, div_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = div_q[VAL_W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("division started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && !busy_q)
    else $error("done without a finished division");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && divisor_i != '0) |-> rem_q < divisor_i)
    else $error("remainder not below divisor");
endmodule
